>>> src/jed_pkg.sv
`default_nettype none

package jed_pkg;

  // field and register widths
  localparam int ADC_BITS_DEF = 10;
  localparam int TS_W         = 32;
  localparam int SHIFT_W      = 4;
  localparam int RATE_W       = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_QUANT_SHIFT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_INTERVAL = 1'd1;

  // register reset values
  localparam logic [SHIFT_W-1:0] QUANT_SHIFT_RST = 4'd6;
  localparam logic [RATE_W-1:0]  RATE_RST        = 16'd100;

endpackage

`default_nettype wire

>>> src/joystick_event_detector.sv
// joystick_event_detector: turns joystick samples into navigation events
//
// input channel (in_valid / in_stall): one sample per transfer with now_ms,
// x_raw, y_raw, sw_level and click_edge. output channel (out_valid /
// out_stall): one result per sample, the five event flags and is_connected.
// config port: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 quant_shift, 1 rate_interval_ms); write only while the block is idle.
//
// a sample lands in the input register, then it is evaluated against the
// tracking state and written to the output register. throughput is one
// sample per cycle while the receiver does not stall, set by that single
// input-register to output-register stage; the state update happens in the
// same cycle the sample moves on, so back-to-back samples see it.
//
// reset (rst, synchronous) empties both registers, restores the register
// defaults and clears the tracking state (switch taken as released).
// when the receiver stalls, the result holds in the output register and one
// more sample is still taken into the input register; after that in_stall
// rises until the output side drains.
`default_nettype none

module joystick_event_detector
  import jed_pkg::*;
#(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // sample channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [TS_W-1:0]       now_ms,
  input  wire logic [ADC_BITS-1:0]   x_raw,
  input  wire logic [ADC_BITS-1:0]   y_raw,
  input  wire logic                  sw_level,
  input  wire logic                  click_edge,
  // event channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       ev_ok,
  output logic                       ev_right,
  output logic                       ev_left,
  output logic                       ev_up,
  output logic                       ev_down,
  output logic                       is_connected
);

  // centred reading plus rounding half needs two extra bits
  localparam int CW = ADC_BITS + 2;
  localparam logic signed [CW-1:0] CENTRE = CW'(1) <<< (ADC_BITS - 1);
  localparam logic [SHIFT_W-1:0] SHIFT_MAX = SHIFT_W'(ADC_BITS - 1);
  localparam logic [SHIFT_W-1:0] SHIFT_MIN = SHIFT_W'(1);

  // configuration registers
  logic [SHIFT_W-1:0] quant_shift;
  logic [RATE_W-1:0]  rate_interval_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      quant_shift      <= QUANT_SHIFT_RST;
      rate_interval_ms <= RATE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_QUANT_SHIFT:   quant_shift      <= cfg_wdata[SHIFT_W-1:0];
        REG_RATE_INTERVAL: rate_interval_ms <= cfg_wdata[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                s1_valid;
  logic [TS_W-1:0]     s1_now;
  logic [ADC_BITS-1:0] s1_x;
  logic [ADC_BITS-1:0] s1_y;
  logic                s1_sw;
  logic                s1_click;

  logic out_load_ok;
  logic adv;

  // output register can take a new result when empty or being drained
  assign out_load_ok = !out_valid || !out_stall;
  assign adv         = s1_valid && out_load_ok;
  assign in_stall    = s1_valid && !out_load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_now   <= now_ms;
      s1_x     <= x_raw;
      s1_y     <= y_raw;
      s1_sw    <= sw_level;
      s1_click <= click_edge;
    end
  end

  // tracking state
  logic [TS_W-1:0]            last_eval_ms;
  logic                       seen_centred;
  logic                       switch_state;
  logic signed [ADC_BITS-1:0] prev_x_pos;
  logic signed [ADC_BITS-1:0] prev_y_pos;
  logic                       click_pending;

  // quantizer, shift clamped into its legal range
  logic [SHIFT_W-1:0]         shift_eff;
  logic signed [CW-1:0]       half;
  logic signed [CW-1:0]       x_cen;
  logic signed [CW-1:0]       y_cen;
  logic signed [CW-1:0]       x_sum;
  logic signed [CW-1:0]       y_sum;
  logic signed [CW-1:0]       x_full;
  logic signed [CW-1:0]       y_full;
  logic signed [ADC_BITS-1:0] xp;
  logic signed [ADC_BITS-1:0] yp;

  always_comb begin
    if (quant_shift < SHIFT_MIN) begin
      shift_eff = SHIFT_MIN;
    end else if (quant_shift > SHIFT_MAX) begin
      shift_eff = SHIFT_MAX;
    end else begin
      shift_eff = quant_shift;
    end
    half   = CW'(1) <<< (shift_eff - SHIFT_MIN);
    // y is inverted so that up is positive
    x_cen  = $signed({2'b00, s1_x}) - CENTRE;
    y_cen  = CENTRE - $signed({2'b00, s1_y});
    x_sum  = x_cen + half;
    y_sum  = y_cen + half;
    x_full = x_sum >>> shift_eff;
    y_full = y_sum >>> shift_eff;
    // shift of at least one keeps the position inside ADC_BITS signed bits
    xp     = x_full[ADC_BITS-1:0];
    yp     = y_full[ADC_BITS-1:0];
  end

  // per-sample evaluation
  logic [TS_W-1:0] elapsed;
  logic            too_early;
  logic            centred_now;
  logic            seen_next;
  logic            eval;
  logic            click_eff;
  logic            level;
  logic            toggle;
  logic            r_ev_ok;
  logic            r_ev_right;
  logic            r_ev_left;
  logic            r_ev_up;
  logic            r_ev_down;

  always_comb begin
    elapsed     = s1_now - last_eval_ms;
    too_early   = elapsed < {{(TS_W-RATE_W){1'b0}}, rate_interval_ms};
    centred_now = (xp == '0) && (yp == '0);
    seen_next   = seen_centred || (!too_early && centred_now);
    eval        = !too_early && seen_next;
    // latched click counts as a press
    click_eff   = click_pending || s1_click;
    level       = click_eff ? 1'b0 : s1_sw;
    toggle      = eval && (level != switch_state);
    r_ev_ok     = toggle && !level;
    r_ev_right  = eval && (xp > prev_x_pos) && (xp > 0);
    r_ev_left   = eval && (xp < prev_x_pos) && (xp < 0);
    r_ev_up     = eval && (yp > prev_y_pos) && (yp > 0);
    r_ev_down   = eval && (yp < prev_y_pos) && (yp < 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_eval_ms  <= '0;
      seen_centred  <= 1'b0;
      switch_state  <= 1'b1;
      prev_x_pos    <= '0;
      prev_y_pos    <= '0;
      click_pending <= 1'b0;
    end else if (adv) begin
      seen_centred  <= seen_next;
      // the click latch runs on every sample, evaluated or not
      click_pending <= toggle ? 1'b0 : click_eff;
      if (toggle) begin
        switch_state <= level;
      end
      if (eval) begin
        last_eval_ms <= s1_now;
        prev_x_pos   <= xp;
        prev_y_pos   <= yp;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load_ok) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ev_ok        <= r_ev_ok;
      ev_right     <= r_ev_right;
      ev_left      <= r_ev_left;
      ev_up        <= r_ev_up;
      ev_down      <= r_ev_down;
      is_connected <= seen_next;
    end
  end

  // no events before the joystick has been seen centred
  a_no_events_unconnected: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_connected |-> !(ev_ok || ev_right || ev_left || ev_up || ev_down))
    else $error("event reported while not connected");

  // opposite directions are exclusive
  a_dir_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(ev_right && ev_left) && !(ev_up && ev_down))
    else $error("opposite direction events together");

  // connection is sticky
  a_connected_sticky: assert property (@(posedge clk) disable iff (rst)
    seen_centred |=> seen_centred)
    else $error("connected flag dropped");

  // a shown press matches the tracked switch state
  a_ok_matches_switch: assert property (@(posedge clk) disable iff (rst)
    out_valid && ev_ok |-> !switch_state)
    else $error("ok event with switch released");

  // upstream is only held off by a full input register
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("stall without pending work");

endmodule

`default_nettype wire

>>> tb/sv/joystick_event_detector_tb.sv
`default_nettype none

module joystick_event_detector_tb
  import jed_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int AXIS_CENTRE = 1 << (ADC_BITS_DEF - 1);
  localparam int AXIS_MAX    = (1 << ADC_BITS_DEF) - 1;
  localparam int STALL_LIMIT = 1000;  // cycles with no transfer before giving up
  localparam int DRAIN_WAIT  = 8;     // two-stage pipeline plus margin

  typedef struct {
    logic [TS_W-1:0]         now_ms;
    logic [ADC_BITS_DEF-1:0] x_raw;
    logic [ADC_BITS_DEF-1:0] y_raw;
    logic                    sw_level;
    logic                    click_edge;
  } sample_t;

  typedef struct packed {
    logic ok;
    logic right;
    logic left;
    logic up;
    logic down;
    logic conn;
  } events_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic [TS_W-1:0]         now_ms;
  logic [ADC_BITS_DEF-1:0] x_raw;
  logic [ADC_BITS_DEF-1:0] y_raw;
  logic                    sw_level;
  logic                    click_edge;
  logic                    out_valid;
  logic                    out_stall;
  logic                    ev_ok;
  logic                    ev_right;
  logic                    ev_left;
  logic                    ev_up;
  logic                    ev_down;
  logic                    is_connected;

  joystick_event_detector i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .now_ms       (now_ms),
    .x_raw        (x_raw),
    .y_raw        (y_raw),
    .sw_level     (sw_level),
    .click_edge   (click_edge),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ev_ok        (ev_ok),
    .ev_right     (ev_right),
    .ev_left      (ev_left),
    .ev_up        (ev_up),
    .ev_down      (ev_down),
    .is_connected (is_connected)
  );

  // events still owed by the block, oldest first
  events_t expected_events[$];
  int      mismatches = 0;
  int      idle_cycles = 0;
  int      rx_wait = 0;
  bit      pace_on = 1'b1;      // when clear, neither side inserts gaps
  bit      sw_hold = 1'b1;      // slowly toggling switch level for random samples
  logic [TS_W-1:0] clock_ms = '0;  // running timestamp of the random stream

  // shadow of the detector: registers and tracking state
  logic [SHIFT_W-1:0] js_shift;
  logic [RATE_W-1:0]  js_rate;
  logic [TS_W-1:0]    js_last_ms;
  logic               js_connected;
  logic               js_switch;
  int                 js_prev_x;
  int                 js_prev_y;
  logic               js_click_latched;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // detector shadow
  // ---------------------------------------------------------------------------

  function automatic void clear_tracking();
    js_shift         = QUANT_SHIFT_RST;
    js_rate          = RATE_RST;
    js_last_ms       = '0;
    js_connected     = 1'b0;
    js_switch        = 1'b1;
    js_prev_x        = 0;
    js_prev_y        = 0;
    js_click_latched = 1'b0;
  endfunction

  // round-to-nearest position: floor((centred + half) / 2^shift), shift clamped
  function automatic int axis_position(int centred);
    int s;
    s = int'(js_shift);
    if (s < 1) s = 1;
    if (s > ADC_BITS_DEF - 1) s = ADC_BITS_DEF - 1;
    return (centred + (1 << (s - 1))) >>> s;
  endfunction

  function automatic events_t detect_events(sample_t s);
    events_t          ev;
    int               xp;
    int               yp;
    logic             level;
    logic [TS_W-1:0]  elapsed;
    ev = '0;
    // a click edge is latched even on samples that are skipped
    if (s.click_edge) js_click_latched = 1'b1;
    xp = axis_position(int'(s.x_raw) - AXIS_CENTRE);
    yp = axis_position(AXIS_CENTRE - int'(s.y_raw));  // up is positive
    elapsed = s.now_ms - js_last_ms;                  // wraps modulo 2^32
    if (elapsed >= {{(TS_W-RATE_W){1'b0}}, js_rate}) begin
      if (!js_connected && xp == 0 && yp == 0) js_connected = 1'b1;
      if (js_connected) begin
        level = js_click_latched ? 1'b0 : s.sw_level;
        if (level != js_switch) begin
          js_switch        = level;
          ev.ok            = (level == 1'b0);
          js_click_latched = 1'b0;
        end
        if (xp > js_prev_x && xp > 0) ev.right = 1'b1;
        else if (xp < js_prev_x && xp < 0) ev.left = 1'b1;
        if (yp > js_prev_y && yp > 0) ev.up = 1'b1;
        else if (yp < js_prev_y && yp < 0) ev.down = 1'b1;
        js_prev_x  = xp;
        js_prev_y  = yp;
        js_last_ms = s.now_ms;
      end
    end
    ev.conn = js_connected;
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic int draw_wait();
    if (!pace_on) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic sample_t make_sample(logic [TS_W-1:0] t, int x, int y,
                                          logic sw, logic click);
    sample_t s;
    s.now_ms     = t;
    s.x_raw      = x[ADC_BITS_DEF-1:0];
    s.y_raw      = y[ADC_BITS_DEF-1:0];
    s.sw_level   = sw;
    s.click_edge = click;
    return s;
  endfunction

  // mix of rails, centre, near-centre and anywhere
  function automatic int pick_axis();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return AXIS_MAX;
      2:       return AXIS_CENTRE;
      3:       return AXIS_CENTRE - 1;
      4, 5:    return AXIS_CENTRE - 128 + int'($urandom_range(0, 255));
      default: return int'($urandom_range(0, AXIS_MAX));
    endcase
  endfunction

  function automatic sample_t random_sample();
    int   rate;
    logic click;
    rate = int'(js_rate);
    // timestamps straddle the rate limit; an occasional jump moves the high bits
    case ($urandom_range(0, 9))
      0:       clock_ms = clock_ms + ((rate == 0) ? 0 : rate - 1);
      1:       clock_ms = clock_ms + rate;
      2:       clock_ms = $urandom;
      3:       clock_ms = clock_ms + $urandom_range(0, rate / 2);
      default: clock_ms = clock_ms + rate + $urandom_range(0, rate / 2 + 20);
    endcase
    if ($urandom_range(0, 3) == 0) sw_hold = ~sw_hold;
    // a click while the switch is held latches for good, so keep it for the end
    click = js_switch && ($urandom_range(0, 5) == 0);
    return make_sample(clock_ms, pick_axis(), pick_axis(), sw_hold, click);
  endfunction

  // one sample transfer; in_valid stays high if the next sample follows at once
  task automatic send_sample(sample_t s);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    now_ms     <= s.now_ms;
    x_raw      <= s.x_raw;
    y_raw      <= s.y_raw;
    sw_level   <= s.sw_level;
    click_edge <= s.click_edge;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_events.push_back(detect_events(s));
  endtask

  // register write with the block drained
  task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_QUANT_SHIFT) js_shift = value[SHIFT_W-1:0];
    else if (idx == REG_RATE_INTERVAL) js_rate = value[RATE_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset defaults: skipped samples, waiting for centre, latched click, rails
  task automatic test_power_up();
    send_sample(make_sample(32'd0,   512,  512,  1'b1, 1'b1));  // too early, click kept
    send_sample(make_sample(32'd150, 1023, 0,    1'b1, 1'b0));  // off centre, not connected
    send_sample(make_sample(32'd160, 0,    1023, 1'b1, 1'b0));
    send_sample(make_sample(32'd170, 512,  512,  1'b1, 1'b0));  // connects, latched click fires
    send_sample(make_sample(32'd270, 1023, 1023, 1'b1, 1'b0));  // right and down
    send_sample(make_sample(32'd370, 0,    0,    1'b1, 1'b0));  // left and up
    send_sample(make_sample(32'd371, 512,  512,  1'b0, 1'b0));  // too early
    send_sample(make_sample(32'd471, 543,  512,  1'b1, 1'b0));  // rounds to centre
    send_sample(make_sample(32'd571, 544,  481,  1'b0, 1'b0));  // switch edge, rounds outward
    send_sample(make_sample(32'd671, 512,  512,  1'b1, 1'b0));
    send_sample(make_sample(32'd680, 512,  512,  1'b1, 1'b1));  // click on a skipped sample
    send_sample(make_sample(32'd771, 512,  512,  1'b1, 1'b0));  // latched click fires
    send_sample(make_sample(32'd871, 512,  512,  1'b1, 1'b0));
  endtask

  task automatic test_rate_limit();
    send_sample(make_sample(js_last_ms + 99,  1023, 512, 1'b1, 1'b0));  // one short
    send_sample(make_sample(js_last_ms + 100, 1023, 512, 1'b1, 1'b0));  // exactly on time
    set_register(REG_RATE_INTERVAL, 16'd0);
    send_sample(make_sample(js_last_ms, 0, 512, 1'b1, 1'b0));  // same timestamp accepted
    send_sample(make_sample(js_last_ms, 0, 0,   1'b1, 1'b0));
    set_register(REG_RATE_INTERVAL, 16'd100);
  endtask

  task automatic test_timestamp_wrap();
    send_sample(make_sample(32'hFFFF_FFF0, 512, 512, 1'b1, 1'b0));
    send_sample(make_sample(32'h0000_0050, 0,   512, 1'b1, 1'b0));  // 96 ms across the wrap
    send_sample(make_sample(32'h0000_0054, 0,   512, 1'b1, 1'b0));  // 100 ms across the wrap
  endtask

  // shift values outside 1 .. ADC_BITS-1 are clamped
  task automatic test_shift_clamp();
    set_register(REG_RATE_INTERVAL, 16'd0);
    set_register(REG_QUANT_SHIFT, 16'd0);
    send_sample(make_sample(32'd1000, 0,    1023, 1'b1, 1'b0));
    send_sample(make_sample(32'd1000, 1023, 0,    1'b1, 1'b0));
    send_sample(make_sample(32'd1000, 512,  512,  1'b1, 1'b0));
    set_register(REG_QUANT_SHIFT, 16'd15);
    send_sample(make_sample(32'd1000, 1023, 0,    1'b1, 1'b0));
    send_sample(make_sample(32'd1000, 0,    1023, 1'b1, 1'b0));
  endtask

  task automatic test_random_stream(logic [SHIFT_W-1:0] shift, logic [RATE_W-1:0] rate,
                                    int count);
    set_register(REG_QUANT_SHIFT, {{(CFG_DATA_W-SHIFT_W){1'b0}}, shift});
    set_register(REG_RATE_INTERVAL, rate);
    clock_ms = js_last_ms;
    for (int i = 0; i < count; i++) begin
      // stretches of back-to-back traffic now and then
      if (i % 40 == 0) pace_on = ($urandom_range(0, 3) != 0);
      send_sample(random_sample());
    end
    pace_on = 1'b1;
  endtask

  // a click latched while the switch is already down stays pending and
  // keeps the switch down from then on, so this runs last
  task automatic test_click_while_pressed();
    set_register(REG_RATE_INTERVAL, 16'd0);
    send_sample(make_sample(clock_ms, 512, 512, 1'b0, 1'b0));
    send_sample(make_sample(clock_ms, 512, 512, 1'b0, 1'b1));
    send_sample(make_sample(clock_ms, 512, 512, 1'b1, 1'b0));  // no release
    send_sample(make_sample(clock_ms, 512, 512, 1'b0, 1'b0));
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  function automatic void check_flag(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      mismatches++;
    end
  endfunction

  // receiver: random stall after each result transfer
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_stall === 1'b0) rx_wait = draw_wait();
    else if (rx_wait != 0) rx_wait--;
    out_stall <= (rx_wait != 0);
  end

  always @(posedge clk) begin
    events_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_events.size() == 0) begin
        $error("result transfer with no sample outstanding");
        mismatches++;
      end else begin
        want = expected_events.pop_front();
        check_flag("ev_ok",        want.ok,    ev_ok);
        check_flag("ev_right",     want.right, ev_right);
        check_flag("ev_left",      want.left,  ev_left);
        check_flag("ev_up",        want.up,    ev_up);
        check_flag("ev_down",      want.down,  ev_down);
        check_flag("is_connected", want.conn,  is_connected);
      end
    end
  end

  // watchdog: too long without any transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst        <= 1'b1;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= REG_QUANT_SHIFT;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    now_ms     <= '0;
    x_raw      <= '0;
    y_raw      <= '0;
    sw_level   <= 1'b1;
    click_edge <= 1'b0;
    out_stall  <= 1'b0;
    clear_tracking();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_power_up();
    test_rate_limit();
    test_timestamp_wrap();
    test_shift_clamp();
    test_random_stream(4'd6,  16'd100,   232);
    test_random_stream(4'd1,  16'd0,     232);
    test_random_stream(4'd9,  16'd65535, 232);
    test_random_stream(4'd0,  16'd1,     232);
    test_random_stream(4'd15, 16'd37,    232);
    test_random_stream(4'd4,  16'($urandom_range(0, 300)), 232);
    test_random_stream(4'($urandom_range(1, 9)), 16'($urandom_range(0, 65535)), 232);
    test_click_while_pressed();

    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> joystick_event_detector.f
src/jed_pkg.sv
src/joystick_event_detector.sv
tb/sv/joystick_event_detector_tb.sv
